// File: hw/rtl/lmn_pkg.sv
// Shared types and codes for the Lamport mutual-exclusion node.
`default_nettype none
package lmn_pkg;

  localparam int LMN_QUEUE_DEPTH = 16;
  localparam int ID_W            = 8;
  localparam int STAMP_W         = 32;
  localparam int CNT8_W          = 8;

  localparam logic [STAMP_W-1:0] CLOCK_MAX = '1;
  localparam logic [CNT8_W-1:0]  RESP_MAX  = '1;

  // event kinds
  localparam logic [2:0] KIND_REQUEST  = 3'd0;
  localparam logic [2:0] KIND_RESPONSE = 3'd1;
  localparam logic [2:0] KIND_RELEASE  = 3'd2;
  localparam logic [2:0] KIND_LOCK     = 3'd3;
  localparam logic [2:0] KIND_UNLOCK   = 3'd4;

  // outgoing message kinds
  localparam logic [1:0] SEND_NONE     = 2'd0;
  localparam logic [1:0] SEND_RESPONSE = 2'd1;
  localparam logic [1:0] SEND_REQUEST  = 2'd2;
  localparam logic [1:0] SEND_RELEASE  = 2'd3;

  // configuration register indexes
  localparam logic CFG_OWN_ID     = 1'b0;
  localparam logic CFG_PEER_COUNT = 1'b1;

  typedef struct packed {
    logic [2:0]         kind;
    logic [ID_W-1:0]    peer_id;
    logic [STAMP_W-1:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         send_kind;
    logic [ID_W-1:0]    send_to;
    logic [STAMP_W-1:0] send_stamp;
    logic               granted;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
  } q_entry_t;

  // command broadcast to every queue cell
  typedef struct packed {
    logic     ins;
    logic     rem;
    q_entry_t new_entry;
    logic [ID_W-1:0] rem_id;
  } cell_cmd_t;

  // signals handed from one cell to its right neighbour
  typedef struct packed {
    logic     ge;
    logic     seen;
    q_entry_t entry;
  } cell_link_t;

endpackage
`default_nettype wire

// File: hw/rtl/lmn_cell.sv
// One slot of the sorted request queue: holds an entry, shifts on insert or remove.
`default_nettype none
module lmn_cell
  import lmn_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_cmd_t  cmd_i,
  input  wire logic       valid_i,
  input  wire cell_link_t left_i,
  input  wire q_entry_t   right_entry_i,
  output cell_link_t      link_o
);

  q_entry_t entry_r;
  q_entry_t entry_nxt;
  logic     lt;
  logic     here;
  logic     match;

  always_comb begin
    lt = (cmd_i.new_entry.stamp < entry_r.stamp) ||
         ((cmd_i.new_entry.stamp == entry_r.stamp) && (cmd_i.new_entry.id < entry_r.id));
    // ge: insert position is at or left of this slot
    link_o.ge    = left_i.ge || !valid_i || lt;
    here         = link_o.ge && !left_i.ge;
    match        = valid_i && (entry_r.id == cmd_i.rem_id);
    link_o.seen  = left_i.seen || match;
    link_o.entry = entry_r;

    entry_nxt = entry_r;
    if (cmd_i.ins) begin
      if (left_i.ge) begin
        entry_nxt = left_i.entry;
      end else if (here) begin
        entry_nxt = cmd_i.new_entry;
      end
    end else if (cmd_i.rem && link_o.seen) begin
      entry_nxt = right_entry_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

// File: hw/rtl/lamport_mutex_node_top.sv
// Lamport mutual-exclusion node: clock, response count, control and the queue cell chain.
//
//   port group | dir | handshake          | payload
//   in_*       | in  | in_valid/in_stall   | in_data   (in_item_t)
//   out_*      | out | out_valid/out_stall | out_data  (out_item_t)
//   cfg_*      | in  | cfg_we             | cfg_index, cfg_wdata
//
// Each event passes through ST_EXEC, which updates clock and queue cells, then ST_DONE,
// which takes the grant from the updated queue head and loads the output register.
// A new event is taken in ST_IDLE, or in ST_DONE as the output loads; never in ST_EXEC.
// Synchronous active-low reset empties the queue (fill count) and clears clock, counts and config.
// A stalled output holds the finished result in ST_DONE and blocks the next event until it can load.
`default_nettype none
module lamport_mutex_node_top
  import lmn_pkg::*;
#(
  parameter int QUEUE_DEPTH = LMN_QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire in_item_t      in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output out_item_t          out_data,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [ID_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DONE} state_t;

  state_t             st_r, st_nxt;
  in_item_t           item_r, item_nxt;
  out_item_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic [STAMP_W-1:0] clock_r, clock_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT8_W-1:0]  resp_r, resp_nxt;
  logic [ID_W-1:0]    own_id_r, own_id_nxt;
  logic [CNT8_W-1:0]  peer_r, peer_nxt;

  logic               can_load, in_acc, full, granted_now;
  logic [STAMP_W-1:0] merged, merged_inc, clock_inc, unlock_clk;
  cell_cmd_t          cmd;

  cell_link_t         link  [QUEUE_DEPTH];
  logic               valid [QUEUE_DEPTH];

  // queue cell chain
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    cell_link_t left;
    q_entry_t   right;
    assign valid[k] = CNT_W'(k) < count_r;
    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = link[k-1];
    end
    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign right = link[k].entry;
    end else begin : g_inner
      assign right = link[k+1].entry;
    end
    lmn_cell u_cell (
      .clk           (clk),
      .cmd_i         (cmd),
      .valid_i       (valid[k]),
      .left_i        (left),
      .right_entry_i (right),
      .link_o        (link[k])
    );
  end

  always_comb begin
    can_load    = !out_valid_r || !out_stall;
    in_stall    = !((st_r == ST_IDLE) || ((st_r == ST_DONE) && can_load));
    in_acc      = in_valid && !in_stall;
    full        = count_r >= CNT_W'(QUEUE_DEPTH);
    granted_now = (resp_r == peer_r) && (count_r != '0) && (link[0].entry.id == own_id_r);

    clock_inc  = (clock_r == CLOCK_MAX) ? clock_r : clock_r + STAMP_W'(1);
    merged     = (item_r.stamp > clock_r) ? item_r.stamp : clock_r;
    merged_inc = (merged == CLOCK_MAX) ? merged : merged + STAMP_W'(1);
    unlock_clk = granted_now ? clock_inc : clock_r;

    st_nxt        = st_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    clock_nxt     = clock_r;
    count_nxt     = count_r;
    resp_nxt      = resp_r;
    own_id_nxt    = own_id_r;
    peer_nxt      = peer_r;

    cmd = '0;
    cmd.new_entry.id    = item_r.peer_id;
    cmd.new_entry.stamp = item_r.stamp;
    cmd.rem_id          = item_r.peer_id;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_ID:     own_id_nxt = cfg_wdata;
        CFG_PEER_COUNT: peer_nxt   = cfg_wdata;
        default:        ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (in_acc) begin
      item_nxt = in_data;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) st_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        res_nxt = '0;
        case (item_r.kind)
          KIND_REQUEST: begin
            cmd.ins            = !full;
            res_nxt.overflow   = full;
            clock_nxt          = merged_inc;
            res_nxt.send_kind  = SEND_RESPONSE;
            res_nxt.send_to    = item_r.peer_id;
            res_nxt.send_stamp = merged_inc;
          end
          KIND_RESPONSE: begin
            if (resp_r != RESP_MAX) resp_nxt = resp_r + CNT8_W'(1);
            clock_nxt = merged_inc;
          end
          KIND_RELEASE: begin
            cmd.rem   = 1'b1;
            clock_nxt = merged_inc;
          end
          KIND_LOCK: begin
            clock_nxt           = clock_inc;
            cmd.ins             = !full;
            cmd.new_entry.id    = own_id_r;
            cmd.new_entry.stamp = clock_inc;
            res_nxt.overflow    = full;
            res_nxt.send_kind   = SEND_REQUEST;
            res_nxt.send_stamp  = clock_inc;
          end
          KIND_UNLOCK: begin
            clock_nxt          = unlock_clk;
            cmd.rem            = 1'b1;
            cmd.rem_id         = own_id_r;
            resp_nxt           = '0;
            res_nxt.send_kind  = SEND_RELEASE;
            res_nxt.send_stamp = unlock_clk;
          end
          default: ;
        endcase
        if (cmd.ins) begin
          count_nxt = count_r + CNT_W'(1);
        end else if (cmd.rem && link[QUEUE_DEPTH-1].seen) begin
          count_nxt = count_r - CNT_W'(1);
        end
        st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (can_load) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt         = res_r;
          out_data_nxt.granted = granted_now;
          st_nxt               = in_acc ? ST_EXEC : ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      clock_r     <= '0;
      count_r     <= '0;
      resp_r      <= '0;
      own_id_r    <= '0;
      peer_r      <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      clock_r     <= clock_nxt;
      count_r     <= count_nxt;
      resp_r      <= resp_nxt;
      own_id_r    <= own_id_nxt;
      peer_r      <= peer_nxt;
    end
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH)) else $error("queue fill count beyond depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> st_r == ST_EXEC) else $error("accepted event not executed");

  a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_EXEC |=> st_r == ST_DONE) else $error("execute cycle not followed by done");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == ST_DONE)) else $error("result without done cycle");

  a_grant_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE) && granted_now |-> count_r != '0) else $error("grant on empty queue");
`endif

endmodule
`default_nettype wire

// File: bench/tb_lamport_mutex_node_top.sv
// Self-checking bench for the Lamport mutex node: directed rows, random traffic, then late rows.
`timescale 1ns / 100ps
module tb_lamport_mutex_node_top;
  import lmn_pkg::*;

  localparam int          QDEPTH      = LMN_QUEUE_DEPTH;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_LEN    = 90;
  localparam int unsigned HOLD_AT_A   = 150;
  localparam int unsigned HOLD_AT_B   = 900;
  localparam int          N_ROWS      = 25;

  // kinds the node has no meaning for
  localparam logic [2:0] KIND_UNDEF_A = 3'd5;
  localparam logic [2:0] KIND_UNDEF_B = 3'd6;
  localparam logic [2:0] KIND_UNDEF_C = 3'd7;

  typedef struct packed {
    logic      late;
    logic      typed;
    in_item_t  ev;
    out_item_t want;
  } stim_row_t;

  logic            clk;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  in_item_t        in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_item_t       out_data;
  logic            cfg_we    = 1'b0;
  logic            cfg_index = 1'b0;
  logic [ID_W-1:0] cfg_wdata = '0;

  lamport_mutex_node_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // late rows drive the clock into saturation, so they close the run
  stim_row_t stim_table [N_ROWS] = '{
    // late  typed  kind          peer   stamp           send_kind      to     stamp   gnt   ovf
    {1'b0, 1'b1, KIND_UNLOCK,   8'h00, 32'h0000_0000, SEND_RELEASE,  8'h00, 32'd0, 1'b0, 1'b0},
    {1'b0, 1'b1, KIND_UNDEF_A,  8'h00, 32'h0000_0000, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b0, 1'b1, KIND_LOCK,     8'h00, 32'h0000_0000, SEND_REQUEST,  8'h00, 32'd1, 1'b1, 1'b0},
    {1'b0, 1'b1, KIND_REQUEST,  8'hFF, 32'h0000_0000, SEND_RESPONSE, 8'hFF, 32'd2, 1'b0, 1'b0},
    {1'b0, 1'b1, KIND_RELEASE,  8'hFF, 32'h0000_0000, SEND_NONE,     8'h00, 32'd0, 1'b1, 1'b0},
    {1'b0, 1'b1, KIND_UNLOCK,   8'h00, 32'h0000_0000, SEND_RELEASE,  8'h00, 32'd4, 1'b0, 1'b0},
    {1'b0, 1'b1, KIND_UNDEF_C,  8'hFF, 32'hFFFF_FFFF, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b0, 1'b0, KIND_REQUEST,  8'h05, 32'h0000_000A, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b0, 1'b0, KIND_REQUEST,  8'h05, 32'h0000_000A, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b0, 1'b0, KIND_REQUEST,  8'h03, 32'h0000_000A, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b0, 1'b0, KIND_REQUEST,  8'hAA, 32'h5555_5555, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b0, 1'b0, KIND_RESPONSE, 8'h55, 32'hAAAA_AAAA, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b0, 1'b0, KIND_LOCK,     8'h00, 32'h0000_0000, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b0, 1'b0, KIND_RELEASE,  8'h09, 32'h0000_0001, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b0, 1'b0, KIND_RELEASE,  8'h05, 32'h0000_000A, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b0, 1'b0, KIND_RELEASE,  8'h03, 32'h0000_000A, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b0, 1'b0, KIND_RELEASE,  8'h05, 32'h0000_000A, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b0, 1'b0, KIND_RELEASE,  8'hAA, 32'h0000_0000, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b0, 1'b0, KIND_UNLOCK,   8'h00, 32'h0000_0000, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b0, 1'b0, KIND_UNDEF_B,  8'h5A, 32'h0000_0003, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b1, 1'b0, KIND_REQUEST,  8'h01, 32'hFFFF_FFFF, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b1, 1'b0, KIND_RESPONSE, 8'h02, 32'hFFFF_FFFE, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b1, 1'b0, KIND_LOCK,     8'h00, 32'h0000_0000, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b1, 1'b0, KIND_UNLOCK,   8'h00, 32'h0000_0000, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0},
    {1'b1, 1'b0, KIND_RELEASE,  8'h01, 32'hFFFF_FFFF, SEND_NONE,     8'h00, 32'd0, 1'b0, 1'b0}
  };

  // node state as the bench predicts it
  logic [STAMP_W-1:0] mdl_clock  = '0;
  logic [ID_W-1:0]    mdl_qid    [QDEPTH];
  logic [STAMP_W-1:0] mdl_qstamp [QDEPTH];
  int                 mdl_fill   = 0;
  logic [CNT8_W-1:0]  mdl_resp   = '0;
  logic [ID_W-1:0]    mdl_own    = '0;
  logic [ID_W-1:0]    mdl_peers  = '0;

  out_item_t   pending_replies [$];
  out_item_t   front_reply;
  int unsigned mismatch_cnt = 0;
  int unsigned replies_seen = 0;
  int unsigned events_sent  = 0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;
  bit          tx_idle_en   = 1'b0;
  bit          rx_idle_en   = 1'b0;
  bit          quiet_tail   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic void clock_tick();
    if (mdl_clock != CLOCK_MAX)
      mdl_clock++;
  endfunction

  function automatic void clock_merge(input logic [STAMP_W-1:0] s);
    if (s > mdl_clock)
      mdl_clock = s;
    clock_tick();
  endfunction

  // sorted insert, new entry goes behind equal keys; returns 1 when dropped
  function automatic logic queue_insert(input logic [ID_W-1:0] id, input logic [STAMP_W-1:0] s);
    int k;
    if (mdl_fill >= QDEPTH)
      return 1'b1;
    k = mdl_fill;
    while (k > 0 && (s < mdl_qstamp[k-1] || (s == mdl_qstamp[k-1] && id < mdl_qid[k-1]))) begin
      mdl_qid[k]    = mdl_qid[k-1];
      mdl_qstamp[k] = mdl_qstamp[k-1];
      k--;
    end
    mdl_qid[k]    = id;
    mdl_qstamp[k] = s;
    mdl_fill++;
    return 1'b0;
  endfunction

  function automatic void queue_drop(input logic [ID_W-1:0] id);
    int k;
    int hit;
    hit = -1;
    for (k = mdl_fill - 1; k >= 0; k--)
      if (mdl_qid[k] == id)
        hit = k;
    if (hit >= 0) begin
      for (k = hit; k + 1 < mdl_fill; k++) begin
        mdl_qid[k]    = mdl_qid[k+1];
        mdl_qstamp[k] = mdl_qstamp[k+1];
      end
      mdl_fill--;
    end
  endfunction

  function automatic logic holds_grant();
    return mdl_resp == mdl_peers && mdl_fill > 0 && mdl_qid[0] == mdl_own;
  endfunction

  function automatic out_item_t next_node_reply(input in_item_t ev);
    out_item_t r;
    r = '0;
    case (ev.kind)
      KIND_REQUEST: begin
        r.overflow   = queue_insert(ev.peer_id, ev.stamp);
        clock_merge(ev.stamp);
        r.send_kind  = SEND_RESPONSE;
        r.send_to    = ev.peer_id;
        r.send_stamp = mdl_clock;
      end
      KIND_RESPONSE: begin
        if (mdl_resp != RESP_MAX)
          mdl_resp++;
        clock_merge(ev.stamp);
      end
      KIND_RELEASE: begin
        queue_drop(ev.peer_id);
        clock_merge(ev.stamp);
      end
      KIND_LOCK: begin
        clock_tick();
        r.overflow   = queue_insert(mdl_own, mdl_clock);
        r.send_kind  = SEND_REQUEST;
        r.send_stamp = mdl_clock;
      end
      KIND_UNLOCK: begin
        if (holds_grant())
          clock_tick();
        r.send_kind  = SEND_RELEASE;
        r.send_stamp = mdl_clock;
        queue_drop(mdl_own);
        mdl_resp = '0;
      end
      default: ;
    endcase
    r.granted = holds_grant();
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic in_item_t mk_event(input logic [2:0] k, input logic [ID_W-1:0] p,
                                        input logic [STAMP_W-1:0] s);
    in_item_t e;
    e.kind    = k;
    e.peer_id = p;
    e.stamp   = s;
    return e;
  endfunction

  // mostly close to the current clock, some tiny (equal keys), some anywhere
  function automatic logic [STAMP_W-1:0] pick_stamp();
    logic [STAMP_W-1:0] near;
    near = (mdl_clock > 32'd3 && mdl_clock < CLOCK_MAX - 32'd8) ? mdl_clock - 32'd3 : 32'd0;
    case ($urandom_range(0, 15))
      0:       return $urandom;
      1, 2:    return $urandom_range(0, 3);
      default: return near + $urandom_range(0, 6);
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_peer();
    logic [ID_W-1:0] p;
    if ($urandom_range(0, 5) == 0)
      p = ID_W'($urandom_range(0, 255));
    else
      p = mdl_own + ID_W'($urandom_range(1, 4));
    return p;
  endfunction

  task automatic push_event(input in_item_t ev, input logic typed, input out_item_t want);
    out_item_t got;
    if (tx_idle_en && !quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall !== 1'b0);
    got = next_node_reply(ev);
    pending_replies = {pending_replies, (typed ? want : got)};
    if (ev.kind <= KIND_UNLOCK)
      events_sent++;
  endtask

  task automatic push_plain(input logic [2:0] k, input logic [ID_W-1:0] p,
                            input logic [STAMP_W-1:0] s);
    push_event(mk_event(k, p, s), 1'b0, '0);
  endtask

  // sender holds back until the node has answered everything
  task automatic pause_for_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  task automatic load_config(input logic [ID_W-1:0] own, input logic [ID_W-1:0] peers);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OWN_ID;
    cfg_wdata <= own;
    @(posedge clk);
    cfg_index <= CFG_PEER_COUNT;
    cfg_wdata <= peers;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mdl_own   = own;
    mdl_peers = peers;
  endtask

  task automatic play_rows(input logic late);
    int i;
    for (i = 0; i < N_ROWS; i++)
      if (stim_table[i].late == late)
        push_event(stim_table[i].ev, stim_table[i].typed, stim_table[i].want);
  endtask

  // one lock/collect round, mostly closed by an unlock, with peer requests and releases woven in
  task automatic run_round();
    int n;
    int k;
    logic [ID_W-1:0] held [$];
    logic [ID_W-1:0] p;
    n = int'(mdl_peers);
    case ($urandom_range(0, 7))
      0:       n = n + 1 + int'($urandom_range(0, 40));
      1:       if (n > 0) n = n - 1;
      default: ;
    endcase
    push_plain(KIND_LOCK, ID_W'($urandom_range(0, 255)), $urandom);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        p = pick_peer();
        push_plain(KIND_REQUEST, p, pick_stamp());
        held = {held, p};
      end
      if (held.size() != 0 && $urandom_range(0, 5) == 0) begin
        p = held[0];
        held.delete(0);
        push_plain(KIND_RELEASE, p, pick_stamp());
      end
      push_plain(KIND_RESPONSE, pick_peer(), pick_stamp());
    end
    if ($urandom_range(0, 7) != 0)
      push_plain(KIND_UNLOCK, ID_W'($urandom_range(0, 255)), $urandom);
    while (held.size() != 0) begin
      p = held[0];
      held.delete(0);
      if ($urandom_range(0, 7) != 0)
        push_plain(KIND_RELEASE, p, pick_stamp());
    end
  endtask

  // a run of peer requests, then their releases in shuffled order
  task automatic run_burst(input int n);
    int k;
    int idx;
    logic [ID_W-1:0] held [$];
    logic [ID_W-1:0] p;
    for (k = 0; k < n; k++) begin
      p = pick_peer();
      push_plain(KIND_REQUEST, p, pick_stamp());
      held = {held, p};
    end
    while (held.size() != 0) begin
      idx = $urandom_range(0, held.size() - 1);
      push_plain(KIND_RELEASE, held[idx], pick_stamp());
      held.delete(idx);
    end
  endtask

  task automatic run_noise();
    int k;
    int n;
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++)
      push_plain(3'($urandom_range(0, 7)), ID_W'($urandom_range(0, 255)),
                 $urandom_range(0, 1) ? pick_stamp() : $urandom);
  endtask

  task automatic run_phase(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = events_sent + quota;
    while (events_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 12)
        run_round();
      else if (pick < 15)
        run_burst($urandom_range(1, 20));
      else
        run_noise();
    end
  endtask

  // ---------------- result side ----------------

  task automatic compare_field(input string tag, input logic [STAMP_W-1:0] want,
                               input logic [STAMP_W-1:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          mismatch_cnt++;
          $display("%0t ns: result transfer, expected none, actual %h", $time, out_data);
        end else begin
          front_reply = pending_replies[0];
          pending_replies.delete(0);
          compare_field("send_kind", STAMP_W'(front_reply.send_kind),
                        STAMP_W'(out_data.send_kind));
          compare_field("send_to", STAMP_W'(front_reply.send_to), STAMP_W'(out_data.send_to));
          compare_field("send_stamp", front_reply.send_stamp, out_data.send_stamp);
          compare_field("granted", STAMP_W'(front_reply.granted), STAMP_W'(out_data.granted));
          compare_field("overflow", STAMP_W'(front_reply.overflow),
                        STAMP_W'(out_data.overflow));
          replies_seen++;
          if (replies_seen == HOLD_AT_A || replies_seen == HOLD_AT_B)
            hold_left = HOLD_LEN;
        end
      end
      // long hold-off lets the node back up into its input
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_idle_en && !quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------- run ----------------

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: own id 0, no peers
    play_rows(1'b0);

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    pause_for_replies();
    load_config(ID_W'($urandom_range(0, 255)), ID_W'($urandom_range(1, 3)));
    run_burst(18);
    run_phase(250);

    pause_for_replies();
    load_config(8'hFF, 8'hFF);
    run_phase(300);

    tx_idle_en = 1'b0;
    pause_for_replies();
    load_config(8'h00, 8'h00);
    run_phase(150);

    tx_idle_en = 1'b1;
    rx_idle_en = 1'($urandom_range(0, 1));
    pause_for_replies();
    load_config(ID_W'($urandom_range(0, 255)), ID_W'($urandom_range(1, 4)));
    run_phase(75);
    pause_for_replies();
    run_phase(75);

    quiet_tail = 1'b1;
    pause_for_replies();
    load_config(ID_W'($urandom_range(0, 255)), ID_W'($urandom_range(1, 2)));
    run_phase(150);
    play_rows(1'b1);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
